// ===== hw/rtl/ptw_pkg.sv =====
package ptw_pkg;

    localparam int POOL_PAGES = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int LEVELS = 4;

    localparam int IDX_W = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int NFP_W = $clog2(POOL_PAGES + 1);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int STORE_DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
    localparam int ADDR_W = PAGE_W + IDX_W;

    localparam int ENTRY_W = 64;
    localparam int VA_W = 48;
    localparam int PA_W = 52;
    localparam int OFS_W = 12;
    localparam int FRAME_W = PA_W - OFS_W;
    localparam int DIFF_W = ENTRY_W - OFS_W;
    localparam int COUNT_W = 16;
    localparam int TOP_SHIFT = 39;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LVL_W-1:0] LEAF_LVL = LVL_W'(LEVELS - 1);

    localparam logic [1:0] FUNC_MAP = 2'd0;
    localparam logic [1:0] FUNC_UNMAP = 2'd1;
    localparam logic [1:0] FUNC_TRANSLATE = 2'd2;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic ok;
        logic [PAGE_W-1:0] page;
    } t_link_res;

endpackage

// ===== hw/rtl/ptw_ram.sv =====
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ptw_link_unit.sv =====
module ptw_link_unit (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [ptw_pkg::ENTRY_W-1:0]   i_entry,
    input  logic [ptw_pkg::FRAME_W-1:0]   i_base_frame,
    input  logic [ptw_pkg::NFP_W-1:0]     i_next_free,
    output ptw_pkg::t_link_res            o_res
);

    logic [ptw_pkg::DIFF_W-1:0] r_diff;
    logic                       r_present;
    logic                       high_zero;

    // The page offset is taken modulo 2^DIFF_W (the entry width less the offset bits), so a link below
    // the pool base wraps to a huge number and fails the range check.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= i_entry[ptw_pkg::ENTRY_W-1:ptw_pkg::OFS_W]
                      - ptw_pkg::DIFF_W'(i_base_frame);
            r_present <= i_entry[0];
        end
    end

    assign high_zero = (r_diff[ptw_pkg::DIFF_W-1:ptw_pkg::PAGE_W] == '0);

    always_comb begin
        o_res.page = r_diff[ptw_pkg::PAGE_W-1:0];
        o_res.ok = r_present && high_zero
                   && (ptw_pkg::NFP_W'(r_diff[ptw_pkg::PAGE_W-1:0]) < i_next_free);
    end

endmodule

// ===== hw/rtl/page_table_map_unmap_translate.sv =====
// Four-level page table with map, unmap and translate requests.
// Input channel: i_valid with the request fields, o_stall from this block. An
// item is taken at a clock edge with i_valid high and o_stall low. Output
// channel: o_valid with the result fields, i_stall from the receiver.
// The pool base register is written by i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// Each level of the walk has three steps: a table read, a registered subtract
// in the shared link decoder and a compare that selects the next table or
// allocates a new one. The leaf level has only the table read and a step
// that writes or reads the leaf entry. A walk that stops at a missing table in
// the first, second or third level goes from its compare to the done state,
// and code 3 goes from idle straight to done. A new item is taken only once
// the result of the last one is registered, at the earliest in the cycle after,
// since the single table read port is needed by each level in turn.
// After reset the block clears all POOL_PAGES * 512 entries of the table store,
// one entry a cycle; o_stall is high meanwhile. Fresh tables are never written
// before they are allocated, so allocation costs no clearing.
// A result held by a stalling receiver does not stop the next item from being
// taken; that item waits in its last state until the output register is free.
module page_table_map_unmap_translate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ptw_pkg::PA_W-1:0]    i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_func,
    input  logic [ptw_pkg::VA_W-1:0]    i_virt_addr,
    input  logic [ptw_pkg::PA_W-1:0]    i_phys_addr,
    input  logic [ptw_pkg::OFS_W-1:0]   i_leaf_flags,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ptw_pkg::PA_W-1:0]    o_translated_addr,
    output logic [1:0]                  o_status,
    output logic                        o_invalidate,
    output logic [ptw_pkg::COUNT_W-1:0] o_mapped_total
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_LINK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [ptw_pkg::ADDR_W-1:0]   r_clr;
    logic [ptw_pkg::PA_W-1:0]     r_base;
    logic [1:0]                   r_func;
    logic [ptw_pkg::VA_W-1:0]     r_va;
    logic [ptw_pkg::PA_W-1:0]     r_pa;
    logic [ptw_pkg::OFS_W-1:0]    r_flags;
    logic [ptw_pkg::LVL_W-1:0]    r_lvl;
    logic [ptw_pkg::PAGE_W-1:0]   r_page;
    logic [ptw_pkg::NFP_W-1:0]    r_nfp;
    logic [ptw_pkg::COUNT_W-1:0]  r_count;
    logic [ptw_pkg::PA_W-1:0]     r_res_addr;
    logic [1:0]                   r_res_status;
    logic                         r_res_inval;
    logic                         r_ovalid;
    logic [ptw_pkg::PA_W-1:0]     r_o_addr;
    logic [1:0]                   r_o_status;
    logic                         r_o_inval;
    logic [ptw_pkg::COUNT_W-1:0]  r_o_total;

    logic [ptw_pkg::IDX_W-1:0]    idx;
    logic [ptw_pkg::ADDR_W-1:0]   slot;
    logic                         ram_we;
    logic [ptw_pkg::ADDR_W-1:0]   ram_waddr;
    logic [ptw_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [ptw_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [ptw_pkg::FRAME_W:0]    link_frame;
    logic [ptw_pkg::ENTRY_W-1:0]  link_entry;
    logic [ptw_pkg::ENTRY_W-1:0]  leaf_entry;
    logic                         pool_full;
    logic                         is_leaf;
    logic                         out_free;
    ptw_pkg::t_link_res           link_res;

    always_comb begin
        case (r_lvl)
            2'd0:    idx = r_va[ptw_pkg::TOP_SHIFT +: ptw_pkg::IDX_W];
            2'd1:    idx = r_va[ptw_pkg::TOP_SHIFT - ptw_pkg::IDX_W +: ptw_pkg::IDX_W];
            2'd2:    idx = r_va[ptw_pkg::TOP_SHIFT - 2 * ptw_pkg::IDX_W +: ptw_pkg::IDX_W];
            default: idx = r_va[ptw_pkg::OFS_W +: ptw_pkg::IDX_W];
        endcase
    end

    assign slot = {r_page, idx};
    assign pool_full = (r_nfp == ptw_pkg::NFP_W'(ptw_pkg::POOL_PAGES));
    assign is_leaf = (r_lvl == ptw_pkg::LEAF_LVL);
    assign out_free = !r_ovalid || !i_stall;

    // A link names the new page relative to the aligned pool base and is
    // marked present and writable.
    assign link_frame = (ptw_pkg::FRAME_W + 1)'(r_base[ptw_pkg::PA_W-1:ptw_pkg::OFS_W])
                        + (ptw_pkg::FRAME_W + 1)'(r_nfp);
    assign link_entry = {{(ptw_pkg::ENTRY_W - ptw_pkg::PA_W - 1){1'b0}}, link_frame,
                         10'b0, 2'b11};
    assign leaf_entry = {{(ptw_pkg::ENTRY_W - ptw_pkg::PA_W){1'b0}},
                         r_pa[ptw_pkg::PA_W-1:ptw_pkg::OFS_W],
                         r_flags[ptw_pkg::OFS_W-1:1], 1'b1};

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = slot;
        ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
            end
            S_EVAL: begin
                if (is_leaf) begin
                    if (r_func == ptw_pkg::FUNC_MAP) begin
                        ram_we = 1'b1;
                        ram_wdata = leaf_entry;
                    end else if (r_func == ptw_pkg::FUNC_UNMAP && ram_rdata[0]) begin
                        ram_we = 1'b1;
                    end
                end
            end
            S_LINK: begin
                if (!link_res.ok && r_func == ptw_pkg::FUNC_MAP && !pool_full) begin
                    ram_we = 1'b1;
                    ram_wdata = link_entry;
                end
            end
            default: begin
            end
        endcase
    end

    ptw_ram #(
        .WIDTH(ptw_pkg::ENTRY_W),
        .DEPTH(ptw_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(slot),
        .o_rdata(ram_rdata)
    );

    ptw_link_unit u_link (
        .i_clk       (i_clk),
        .i_load      (r_state == S_EVAL),
        .i_entry     (ram_rdata),
        .i_base_frame(r_base[ptw_pkg::PA_W-1:ptw_pkg::OFS_W]),
        .i_next_free (r_nfp),
        .o_res       (link_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ptw_pkg::ADDR_W'(ptw_pkg::STORE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_func == ptw_pkg::FUNC_NOP) ? S_DONE : S_RD;
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: n_state = is_leaf ? S_DONE : S_LINK;
            S_LINK: begin
                if (link_res.ok || (r_func == ptw_pkg::FUNC_MAP && !pool_full)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_base <= '0;
            r_nfp <= ptw_pkg::NFP_W'(1);
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_lvl <= '0;
            r_page <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ptw_pkg::ADDR_W'(1);
            end
            if (r_state == S_IDLE && i_valid) begin
                r_lvl <= '0;
                r_page <= '0;
            end
            if (r_state == S_EVAL && is_leaf) begin
                if (r_func == ptw_pkg::FUNC_MAP) begin
                    if (!ram_rdata[0] && r_count != ptw_pkg::COUNT_MAX) begin
                        r_count <= r_count + ptw_pkg::COUNT_W'(1);
                    end
                end else if (r_func == ptw_pkg::FUNC_UNMAP) begin
                    if (ram_rdata[0] && r_count != '0) begin
                        r_count <= r_count - ptw_pkg::COUNT_W'(1);
                    end
                end
            end
            if (r_state == S_LINK) begin
                if (link_res.ok) begin
                    r_page <= link_res.page;
                    r_lvl <= r_lvl + ptw_pkg::LVL_W'(1);
                end else if (r_func == ptw_pkg::FUNC_MAP && !pool_full) begin
                    r_page <= r_nfp[ptw_pkg::PAGE_W-1:0];
                    r_nfp <= r_nfp + ptw_pkg::NFP_W'(1);
                    r_lvl <= r_lvl + ptw_pkg::LVL_W'(1);
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_func <= i_func;
            r_va <= i_virt_addr;
            r_pa <= i_phys_addr;
            r_flags <= i_leaf_flags;
            r_res_addr <= '0;
            r_res_status <= ptw_pkg::STATUS_DONE;
            r_res_inval <= 1'b0;
        end
        if (r_state == S_EVAL && is_leaf) begin
            if (r_func == ptw_pkg::FUNC_TRANSLATE) begin
                if (ram_rdata[0]) begin
                    r_res_addr <= {ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::OFS_W],
                                   r_va[ptw_pkg::OFS_W-1:0]};
                end else begin
                    r_res_status <= ptw_pkg::STATUS_ABSENT;
                end
            end else begin
                r_res_inval <= 1'b1;
                if (r_func == ptw_pkg::FUNC_UNMAP && !ram_rdata[0]) begin
                    r_res_status <= ptw_pkg::STATUS_ABSENT;
                end
            end
        end
        if (r_state == S_LINK && !link_res.ok) begin
            if (r_func != ptw_pkg::FUNC_MAP) begin
                r_res_status <= ptw_pkg::STATUS_ABSENT;
            end else if (pool_full) begin
                r_res_status <= ptw_pkg::STATUS_EXHAUSTED;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_o_addr <= r_res_addr;
            r_o_status <= r_res_status;
            r_o_inval <= r_res_inval;
            r_o_total <= r_count;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_translated_addr = r_o_addr;
    assign o_status = r_o_status;
    assign o_invalidate = r_o_inval;
    assign o_mapped_total = r_o_total;

endmodule

// ===== hw/rtl/ptw_checker.sv =====
module ptw_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [ptw_pkg::PA_W-1:0]    o_translated_addr,
    input logic [1:0]                  o_status,
    input logic                        o_invalidate,
    input logic [ptw_pkg::COUNT_W-1:0] o_mapped_total
);

    // Reset leaves no result pending and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("result or ready state right after reset");

    // A map that ran out of table pages never asks for invalidation.
    a_no_inval_on_exhaust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ptw_pkg::STATUS_EXHAUSTED |-> !o_invalidate)
        else $error("invalidate raised on pool exhaustion");

    // Only a successful translate returns a nonzero address.
    a_addr_only_translate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_translated_addr != '0
        |-> o_status == ptw_pkg::STATUS_DONE && !o_invalidate)
        else $error("address returned by a failing or updating request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_translated_addr)
                               && $stable(o_status) && $stable(o_mapped_total))
        else $error("stalled result changed");

endmodule

bind page_table_map_unmap_translate ptw_checker u_ptw_checker (.*);
